// ----- design/ufte_pkg.sv -----
// ----------------------------------------------------------------------------
// ufte_pkg
// Shared types and codes of the UDP flow table: function codes, result
// events, register indexes, the flow key and the controller states.
// ----------------------------------------------------------------------------
package ufte_pkg;

  typedef struct packed {
    logic [15:0] tport;
    logic [31:0] tip;
    logic [15:0] cport;
    logic [31:0] cip;
  } key_t;

  localparam logic [1:0] FN_PACKET  = 2'd0;
  localparam logic [1:0] FN_TICK    = 2'd1;
  localparam logic [1:0] FN_SWEEP   = 2'd2;
  localparam logic [1:0] FN_REFRESH = 2'd3;

  localparam logic [2:0] EV_HIT       = 3'd0;
  localparam logic [2:0] EV_OPENED    = 3'd1;
  localparam logic [2:0] EV_EVICTED   = 3'd2;
  localparam logic [2:0] EV_EXPIRED   = 3'd3;
  localparam logic [2:0] EV_NONE_EXP  = 3'd4;
  localparam logic [2:0] EV_TICK      = 3'd5;
  localparam logic [2:0] EV_REFRESHED = 3'd6;
  localparam logic [2:0] EV_NOT_OPEN  = 3'd7;

  localparam logic CFG_IDLE_LIMIT = 1'b0;
  localparam logic CFG_MAX_FLOWS  = 1'b1;

  localparam logic [15:0] IDLE_LIMIT_RESET = 16'd90;
  localparam logic [6:0]  MAX_FLOWS_RESET  = 7'd64;
  localparam logic [6:0]  MAX_RESULTS      = 7'd64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_WAVE,
    S_PKT,
    S_SWEEP
  } state_t;

endpackage

// ----- design/ufte_cell.sv -----
// ----------------------------------------------------------------------------
// ufte_cell
// One table entry. Holds the flow key and timestamps, and passes the running
// hit, free-slot and oldest-entry candidates on to the next cell each cycle.
// ----------------------------------------------------------------------------
module ufte_cell
  import ufte_pkg::*;
#(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  key_t          key_i,
  input  logic [31:0]   now_i,
  input  logic [31:0]   cc_i,
  input  logic [15:0]   limit_i,
  input  logic          close_i,
  input  logic          touch_i,
  input  logic          open_i,
  input  logic          hit_v_i,
  input  logic [IW-1:0] hit_idx_i,
  input  logic          free_v_i,
  input  logic [IW-1:0] free_idx_i,
  input  logic          best_v_i,
  input  logic [31:0]   best_age_i,
  input  logic [31:0]   best_cage_i,
  input  logic [IW-1:0] best_idx_i,
  output logic          hit_v_o,
  output logic [IW-1:0] hit_idx_o,
  output logic          free_v_o,
  output logic [IW-1:0] free_idx_o,
  output logic          best_v_o,
  output logic [31:0]   best_age_o,
  output logic [31:0]   best_cage_o,
  output logic [IW-1:0] best_idx_o,
  output logic          open_o,
  output logic          exp_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic        open_q;
  key_t        key_q;
  logic [31:0] last_q;
  logic [31:0] co_q;
  logic [31:0] age;
  logic [31:0] cage;
  logic        older;

  assign age    = now_i - last_q;
  assign cage   = cc_i - co_q;
  assign open_o = open_q;
  assign exp_o  = open_q && (age > {16'b0, limit_i});
  assign older  = !best_v_i || (age > best_age_i) ||
                  (age == best_age_i && cage > best_cage_i);

  always_ff @(posedge clk) begin
    if (rst) begin
      open_q <= 1'b0;
    end else if (open_i) begin
      open_q <= 1'b1;
    end else if (close_i) begin
      open_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (open_i) begin
      key_q  <= key_i;
      last_q <= now_i;
      co_q   <= cc_i;
    end else if (touch_i) begin
      last_q <= now_i;
    end
  end

  // candidate chain: lower cells win hits and free slots, strict older wins
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_v_o  <= 1'b0;
      free_v_o <= 1'b0;
      best_v_o <= 1'b0;
    end else begin
      if (hit_v_i || !(open_q && key_q == key_i)) begin
        hit_v_o   <= hit_v_i;
        hit_idx_o <= hit_idx_i;
      end else begin
        hit_v_o   <= 1'b1;
        hit_idx_o <= MY_IDX;
      end
      if (free_v_i || open_q) begin
        free_v_o   <= free_v_i;
        free_idx_o <= free_idx_i;
      end else begin
        free_v_o   <= 1'b1;
        free_idx_o <= MY_IDX;
      end
      if (open_q && older) begin
        best_v_o    <= 1'b1;
        best_age_o  <= age;
        best_cage_o <= cage;
        best_idx_o  <= MY_IDX;
      end else begin
        best_v_o    <= best_v_i;
        best_age_o  <= best_age_i;
        best_cage_o <= best_cage_i;
        best_idx_o  <= best_idx_i;
      end
    end
  end

endmodule

// ----- design/udp_flow_table_with_eviction.sv -----
// ----------------------------------------------------------------------------
// udp_flow_table_with_eviction
// Table of open UDP flows with lookup, open, oldest-entry eviction, seconds
// tick, activity refresh and idle sweep.
//
//   channel | dir | signals                          | content
//   s_      | in  | tvalid tready tdata tuser        | request, tuser = func
//   m_      | out | tvalid tready tdata tlast         | result, tlast = last_of_run
//   cfg_    | in  | we addr wdata                    | register writes
//
// One item at a time: a new request is taken only in the idle state. A packet
// waits for the candidate wave through the cell chain; a sweep scans one slot
// per cycle, holding on an expired slot while the result is stalled, and ends
// at the last expired slot, at the MAX_RESULTS-th result or at the table's end.
// Synchronous reset clears all entries; no clearing pass is needed.
// A stalled result holds the controller until it is taken.
// ----------------------------------------------------------------------------
module udp_flow_table_with_eviction
  import ufte_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // cip[31:0] cport[47:32] tip[79:48] tport[95:80] refresh_slot[101:96]
  input  logic [103:0] s_tdata,
  // func[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // event_res[2:0] slot[8:3] evicted_slot[14:9] open_count[21:15]
  output logic [23:0]  m_tdata,
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_t state, state_next;

  logic [15:0]   limit_q;
  logic [6:0]    max_q;
  logic [1:0]    func_q;
  key_t          key_q;
  logic [5:0]    rs_q;
  logic [31:0]   now_q;
  logic [31:0]   cc_q;
  logic [CW-1:0] cnt_q, cnt_next;
  logic [CW-1:0] wave_q;
  logic [CW-1:0] idx_q;
  logic [6:0]    n_q;

  logic          m_valid_q;
  logic [2:0]    ev_q;
  logic [5:0]    slot_q, evs_q;
  logic [6:0]    oc_q;
  logic          last_q;

  logic [TABLE_DEPTH-1:0] close_v, touch_v, open_v, open_vec, exp_vec;
  logic          hit_v  [TABLE_DEPTH+1];
  logic [IW-1:0] hit_i  [TABLE_DEPTH+1];
  logic          free_v [TABLE_DEPTH+1];
  logic [IW-1:0] free_i [TABLE_DEPTH+1];
  logic          best_v [TABLE_DEPTH+1];
  logic [31:0]   best_a [TABLE_DEPTH+1];
  logic [31:0]   best_c [TABLE_DEPTH+1];
  logic [IW-1:0] best_i [TABLE_DEPTH+1];

  logic          accept, out_free;
  logic [CW-1:0] lim_eff;
  logic          need_ev;
  logic [IW-1:0] new_slot, rs_idx, sw_idx;
  logic          rs_ok, idx_end, sw_exp, sw_more, sw_last;
  logic          emit, now_inc, cc_inc, idx_inc, n_inc, clr_scan;
  logic [2:0]    e_ev;
  logic [IW-1:0] e_slot, e_evs;
  logic [5:0]    e_slot6;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_valid_q || m_tready;
  assign s_tready = (state == S_IDLE);

  assign m_tvalid = m_valid_q;
  assign m_tlast  = last_q;
  assign m_tdata  = {2'b0, oc_q, evs_q, slot_q, ev_q};

  // clamp the limit to 1..TABLE_DEPTH
  always_comb begin
    if (max_q == 7'd0) begin
      lim_eff = CW'(1);
    end else if (16'(max_q) > 16'(TABLE_DEPTH)) begin
      lim_eff = DEPTH_C;
    end else begin
      lim_eff = CW'(max_q);
    end
  end

  assign need_ev  = (cnt_q >= lim_eff) || !free_v[TABLE_DEPTH];
  assign new_slot = (free_v[TABLE_DEPTH] && free_i[TABLE_DEPTH] < best_i[TABLE_DEPTH]) ?
                    free_i[TABLE_DEPTH] : best_i[TABLE_DEPTH];
  assign rs_idx   = IW'(16'(rs_q));
  assign rs_ok    = (16'(rs_q) < 16'(TABLE_DEPTH)) && open_vec[rs_idx];
  assign sw_idx   = idx_q[IW-1:0];
  assign idx_end  = (idx_q == DEPTH_C);
  assign sw_exp   = !idx_end && exp_vec[sw_idx];
  assign sw_more  = |((exp_vec >> sw_idx) >> 1);
  assign sw_last  = !sw_more || (n_q == MAX_RESULTS - 7'd1);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (func_q == FN_PACKET) state_next = S_WAVE;
        else if (func_q == FN_SWEEP) state_next = S_SWEEP;
        else if (out_free) state_next = S_IDLE;
      end
      S_WAVE: begin
        if (wave_q == DEPTH_C) state_next = S_PKT;
      end
      S_PKT: begin
        if (out_free) state_next = S_IDLE;
      end
      S_SWEEP: begin
        if (out_free && (idx_end || (sw_exp && sw_last))) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    emit     = 1'b0;
    e_ev     = EV_HIT;
    e_slot   = '0;
    e_evs    = '0;
    e_slot6  = 6'd0;
    now_inc  = 1'b0;
    cc_inc   = 1'b0;
    idx_inc  = 1'b0;
    n_inc    = 1'b0;
    clr_scan = 1'b0;
    cnt_next = cnt_q;
    close_v  = '0;
    touch_v  = '0;
    open_v   = '0;
    case (state)
      S_DISPATCH: begin
        clr_scan = 1'b1;
        if (func_q == FN_TICK && out_free) begin
          now_inc = 1'b1;
          emit    = 1'b1;
          e_ev    = EV_TICK;
        end else if (func_q == FN_REFRESH && out_free) begin
          emit    = 1'b1;
          e_slot6 = rs_q;
          if (rs_ok) begin
            touch_v[rs_idx] = 1'b1;
            e_ev = EV_REFRESHED;
          end else begin
            e_ev = EV_NOT_OPEN;
          end
        end
      end
      S_PKT: begin
        if (out_free) begin
          emit = 1'b1;
          if (hit_v[TABLE_DEPTH]) begin
            touch_v[hit_i[TABLE_DEPTH]] = 1'b1;
            e_ev   = EV_HIT;
            e_slot = hit_i[TABLE_DEPTH];
          end else if (need_ev) begin
            close_v[best_i[TABLE_DEPTH]] = 1'b1;
            open_v[new_slot] = 1'b1;
            cc_inc = 1'b1;
            e_ev   = EV_EVICTED;
            e_slot = new_slot;
            e_evs  = best_i[TABLE_DEPTH];
          end else begin
            open_v[free_i[TABLE_DEPTH]] = 1'b1;
            cc_inc   = 1'b1;
            cnt_next = cnt_q + CW'(1);
            e_ev     = EV_OPENED;
            e_slot   = free_i[TABLE_DEPTH];
          end
        end
      end
      S_SWEEP: begin
        if (idx_end) begin
          if (out_free) begin
            emit = 1'b1;
            e_ev = EV_NONE_EXP;
          end
        end else if (sw_exp) begin
          if (out_free) begin
            close_v[sw_idx] = 1'b1;
            cnt_next = cnt_q - CW'(1);
            emit     = 1'b1;
            e_ev     = EV_EXPIRED;
            e_slot   = sw_idx;
            idx_inc  = 1'b1;
            n_inc    = 1'b1;
          end
        end else begin
          idx_inc = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      limit_q <= IDLE_LIMIT_RESET;
      max_q   <= MAX_FLOWS_RESET;
      now_q   <= '0;
      cc_q    <= '0;
      cnt_q   <= '0;
      wave_q  <= '0;
      idx_q   <= '0;
      n_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_addr == CFG_IDLE_LIMIT) limit_q <= cfg_wdata;
        else max_q <= cfg_wdata[6:0];
      end
      if (now_inc) now_q <= now_q + 32'd1;
      if (cc_inc) cc_q <= cc_q + 32'd1;
      cnt_q <= cnt_next;
      if (clr_scan) begin
        wave_q <= '0;
        idx_q  <= '0;
        n_q    <= '0;
      end else begin
        if (state == S_WAVE) wave_q <= wave_q + CW'(1);
        if (idx_inc) idx_q <= idx_q + CW'(1);
        if (n_inc) n_q <= n_q + 7'd1;
      end
      if (emit) m_valid_q <= 1'b1;
      else if (m_tready) m_valid_q <= 1'b0;
    end
  end

  // hold the request fields and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q    <= s_tuser;
      key_q.cip   <= s_tdata[31:0];
      key_q.cport <= s_tdata[47:32];
      key_q.tip   <= s_tdata[79:48];
      key_q.tport <= s_tdata[95:80];
      rs_q      <= s_tdata[101:96];
    end
    if (emit) begin
      ev_q   <= e_ev;
      slot_q <= (state == S_DISPATCH) ? e_slot6 : 6'(16'(e_slot));
      evs_q  <= 6'(16'(e_evs));
      oc_q   <= 7'(16'(cnt_next));
      last_q <= (state == S_SWEEP && sw_exp) ? sw_last : 1'b1;
    end
  end

  assign hit_v[0]  = 1'b0;
  assign hit_i[0]  = '0;
  assign free_v[0] = 1'b0;
  assign free_i[0] = '0;
  assign best_v[0] = 1'b0;
  assign best_a[0] = '0;
  assign best_c[0] = '0;
  assign best_i[0] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ufte_cell #(.IW(IW), .IDX(g)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .key_i       (key_q),
      .now_i       (now_q),
      .cc_i        (cc_q),
      .limit_i     (limit_q),
      .close_i     (close_v[g]),
      .touch_i     (touch_v[g]),
      .open_i      (open_v[g]),
      .hit_v_i     (hit_v[g]),
      .hit_idx_i   (hit_i[g]),
      .free_v_i    (free_v[g]),
      .free_idx_i  (free_i[g]),
      .best_v_i    (best_v[g]),
      .best_age_i  (best_a[g]),
      .best_cage_i (best_c[g]),
      .best_idx_i  (best_i[g]),
      .hit_v_o     (hit_v[g+1]),
      .hit_idx_o   (hit_i[g+1]),
      .free_v_o    (free_v[g+1]),
      .free_idx_o  (free_i[g+1]),
      .best_v_o    (best_v[g+1]),
      .best_age_o  (best_a[g+1]),
      .best_cage_o (best_c[g+1]),
      .best_idx_o  (best_i[g+1]),
      .open_o      (open_vec[g]),
      .exp_o       (exp_vec[g])
    );
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    32'($countones(open_vec)) == 32'(cnt_q))
    else $error("open count out of step with open entries");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_q <= DEPTH_C)
    else $error("open count beyond table depth");

  a_evict_has_victim: assert property (@(posedge clk) disable iff (rst)
    (state == S_PKT && out_free && !hit_v[TABLE_DEPTH] && need_ev) |->
    best_v[TABLE_DEPTH])
    else $error("eviction without an open entry");

endmodule

// ----- tb/sv/ufte_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ufte_checker
// Watches the request, result and register-write ports of the flow table.
// Keeps a cycle-free model of the table, queues the results each accepted
// request must produce and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module ufte_checker
  import ufte_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [103:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [23:0]  m_tdata,
  input  logic         m_tlast,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [15:0]  cfg_wdata,
  output int           errors,
  output int           pending
);

  localparam int DEPTH = 64;

  typedef struct packed {
    logic [2:0] ev;
    logic [5:0] slot;
    logic [5:0] evicted;
    logic [6:0] count;
    logic       last;
  } flow_result_t;

  flow_result_t events_due[$];

  logic        is_open [DEPTH];
  key_t        keys    [DEPTH];
  logic [31:0] seen    [DEPTH];
  logic [31:0] born    [DEPTH];
  logic [31:0] now_s;
  logic [31:0] born_ctr;
  logic [6:0]  n_open;
  logic [15:0] idle_lim;
  logic [6:0]  max_flows;

  task automatic add_event(logic [2:0] ev, int slot, int evicted);
    flow_result_t r;
    r.ev = ev;
    r.slot = slot[5:0];
    r.evicted = evicted[5:0];
    r.count = n_open;
    r.last = 1'b0;
    events_due.push_back(r);
  endtask

  function automatic int first_free();
    for (int i = 0; i < DEPTH; i++)
      if (!is_open[i]) return i;
    return -1;
  endfunction

  task automatic track_request(logic [1:0] fn, logic [103:0] d);
    key_t        k;
    int          hit, victim, slot, lim, rs, n;
    logic [31:0] age, cage, best_age, best_cage;
    k = d[95:0];
    rs = d[101:96];
    n = 0;
    case (fn)
      FN_PACKET: begin
        hit = -1;
        for (int i = 0; i < DEPTH; i++)
          if (hit < 0 && is_open[i] && keys[i] == k) hit = i;
        if (hit >= 0) begin
          seen[hit] = now_s;
          add_event(EV_HIT, hit, 0);
        end else begin
          lim = (max_flows < 1) ? 1 : (max_flows > DEPTH) ? DEPTH : max_flows;
          victim = -1;
          if (n_open >= lim || first_free() < 0) begin
            best_age = 0;
            best_cage = 0;
            for (int i = 0; i < DEPTH; i++) begin
              if (!is_open[i]) continue;
              age = now_s - seen[i];
              cage = born_ctr - born[i];
              if (victim < 0 || age > best_age || (age == best_age && cage > best_cage)) begin
                victim = i;
                best_age = age;
                best_cage = cage;
              end
            end
            if (victim >= 0) begin
              is_open[victim] = 1'b0;
              if (n_open > 0) n_open--;
            end
          end
          slot = first_free();
          if (slot < 0) slot = 0;
          is_open[slot] = 1'b1;
          keys[slot] = k;
          seen[slot] = now_s;
          born[slot] = born_ctr;
          born_ctr++;
          n_open++;
          if (victim >= 0) add_event(EV_EVICTED, slot, victim);
          else add_event(EV_OPENED, slot, 0);
        end
      end
      FN_TICK: begin
        now_s++;
        add_event(EV_TICK, 0, 0);
      end
      FN_SWEEP: begin
        for (int i = 0; i < DEPTH && n < MAX_RESULTS; i++) begin
          if (is_open[i] && (now_s - seen[i]) > {16'd0, idle_lim}) begin
            is_open[i] = 1'b0;
            if (n_open > 0) n_open--;
            add_event(EV_EXPIRED, i, 0);
            n++;
          end
        end
        if (n == 0) add_event(EV_NONE_EXP, 0, 0);
      end
      default: begin
        if (is_open[rs]) begin
          seen[rs] = now_s;
          add_event(EV_REFRESHED, rs, 0);
        end else begin
          add_event(EV_NOT_OPEN, rs, 0);
        end
      end
    endcase
    events_due[events_due.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    flow_result_t want, got;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) is_open[i] = 1'b0;
      now_s = '0;
      born_ctr = '0;
      n_open = '0;
      idle_lim = IDLE_LIMIT_RESET;
      max_flows = MAX_FLOWS_RESET;
      events_due.delete();
      errors = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[2:0], m_tdata[8:3], m_tdata[14:9], m_tdata[21:15], m_tlast};
        if (events_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result transaction %h", $realtime, got);
        end else begin
          want = events_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch ev %0d/%0d slot %0d/%0d evicted %0d/%0d count %0d/%0d last %0d/%0d (exp/act)",
                $realtime, want.ev, got.ev, want.slot, got.slot, want.evicted, got.evicted,
                want.count, got.count, want.last, got.last);
          end
        end
      end
      if (s_tvalid && s_tready) track_request(s_tuser, s_tdata);
      if (cfg_we) begin
        if (cfg_addr == CFG_IDLE_LIMIT) idle_lim = cfg_wdata;
        else max_flows = cfg_wdata[6:0];
      end
    end
    pending = events_due.size();
  end

endmodule

// ----- tb/sv/tb_udp_flow_table_with_eviction.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_udp_flow_table_with_eviction
// Drives the flow table with directed packets, ticks, sweeps and refreshes,
// then random traffic over a small key pool, under four idling patterns and
// several register settings. The checker predicts and compares all results.
// ----------------------------------------------------------------------------
module tb_udp_flow_table_with_eviction;
  import ufte_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic [1:0]   s_tuser = FN_TICK;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [23:0]  m_tdata;
  logic         m_tlast;
  logic         cfg_we = 1'b0;
  logic         cfg_addr = CFG_IDLE_LIMIT;
  logic [15:0]  cfg_wdata = '0;
  int           errors;
  int           pending;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  key_t         pool [80];

  always #5 clk = ~clk;

  udp_flow_table_with_eviction i_dut (.*);

  ufte_checker i_checker (.*);

  always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  task automatic send(logic [1:0] fn, key_t k, logic [5:0] rs);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= fn;
    s_tdata <= {2'b00, rs, k};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic packet(key_t k);
    send(FN_PACKET, k, 6'($urandom));
  endtask

  task automatic op(logic [1:0] fn, logic [5:0] rs = 6'd0);
    send(fn, key_t'({$urandom, $urandom, $urandom}), rs);
  endtask

  // drain outstanding results, then let a packet or sweep in flight settle
  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic key_t rand_key();
    return key_t'({$urandom, $urandom, $urandom});
  endfunction

  task automatic random_run(int items, int pool_size);
    int r;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (r < 50) packet(r < 45 ? pool[$urandom_range(pool_size - 1)] : rand_key());
      else if (r < 70) op(FN_TICK);
      else if (r < 80) op(FN_SWEEP);
      else op(FN_REFRESH, 6'($urandom));
    end
  endtask

  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 80; i++) pool[i] = rand_key();

    // directed: empty sweep, tick, unopened refresh, extreme keys, hit
    op(FN_SWEEP);
    op(FN_TICK);
    op(FN_REFRESH, 6'd63);
    op(FN_REFRESH, 6'd0);
    packet('0);
    packet('1);
    packet('0);
    op(FN_REFRESH, 6'd1);
    // force eviction with ties on last-seen time: earliest created goes
    write_reg(CFG_MAX_FLOWS, 16'd2);
    packet(pool[0]);
    packet(pool[1]);
    op(FN_TICK);
    packet(pool[1]);
    packet(pool[2]);
    // lower the limit below the open count
    write_reg(CFG_MAX_FLOWS, 16'd1);
    packet(pool[3]);
    packet(pool[4]);
    write_reg(CFG_MAX_FLOWS, 16'd0);
    packet(pool[5]);
    write_reg(CFG_IDLE_LIMIT, 16'd0);
    op(FN_SWEEP);
    op(FN_TICK);
    op(FN_SWEEP);
    write_reg(CFG_IDLE_LIMIT, 16'hFFFF);
    write_reg(CFG_MAX_FLOWS, 16'd127);
    packet(pool[6]);
    op(FN_SWEEP);

    // fill past the table depth, no idling
    write_reg(CFG_MAX_FLOWS, 16'd64);
    for (int i = 0; i < 70; i++) packet(pool[i]);
    op(FN_TICK);
    packet(pool[75]);

    send_idle_pct = 84;
    write_reg(CFG_IDLE_LIMIT, 16'd2);
    write_reg(CFG_MAX_FLOWS, 16'd8);
    random_run(25, 12);

    send_idle_pct = 0;
    stall_pct = 84;
    write_reg(CFG_IDLE_LIMIT, 16'd0);
    write_reg(CFG_MAX_FLOWS, 16'd64);
    random_run(20, 80);

    send_idle_pct = 12;
    stall_pct = 12;
    write_reg(CFG_IDLE_LIMIT, 16'd90);
    write_reg(CFG_MAX_FLOWS, 16'd3);
    random_run(25, 6);
    stall_pct = 0;
    send_idle_pct = 0;
    write_reg(CFG_IDLE_LIMIT, 16'd1);
    random_run(20, 20);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
